[src/mld_pkg.sv]
// mld_pkg: shared types, constants and helper functions for the marker length deframer
// depends on nothing; used by mld_match, mld_core and marker_length_deframer
package mld_pkg;

   // number of little-endian length bytes that follow the marker (1 to 8)
   localparam int LENGTH_BYTES = 8;
   localparam int LEN_BITS     = 8 * LENGTH_BYTES;

   // sync marker length in bytes
   localparam int MARKER_LEN = 10;

   localparam logic [3:0]  MARKER_LEN_CODE   = 4'(MARKER_LEN);
   localparam logic [7:0]  MARKER_FIRST_BYTE = 8'h44;
   localparam logic [31:0] MAX_LEN_RESET     = 32'd65536;

   typedef enum logic [1:0] {
      PHASE_HUNT    = 2'd0,
      PHASE_LENGTH  = 2'd1,
      PHASE_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_PAYLOAD = 2'd0,
      STATUS_ABORT   = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_REJECT  = 2'd3
   } status_type;

   // one result item from the core to the output register
   typedef struct packed {
      logic       valid;
      logic [7:0] payload_byte;
      logic       last;
      status_type status;
   } result_type;

   // marker byte at a given position, zero past the end
   function automatic logic [7:0] marker_byte(input logic [3:0] idx);
      logic [7:0] val;
      unique case (idx)
         4'd0:    val = 8'h44; // D
         4'd1:    val = 8'h41; // A
         4'd2:    val = 8'h54; // T
         4'd3:    val = 8'h41; // A
         4'd4:    val = 8'h5F; // _
         4'd5:    val = 8'h53; // S
         4'd6:    val = 8'h54; // T
         4'd7:    val = 8'h41; // A
         4'd8:    val = 8'h52; // R
         4'd9:    val = 8'h54; // T
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

[src/marker_length_deframer.sv]
// marker_length_deframer: top level with input register, deframing core and result register
// depends on mld_pkg and mld_core
//
// Takes one stream byte per request and sustains one request per clock cycle unless
// the receiver stalls. A byte waits in the input register and is processed on its way
// into the result register, where its result is presented. While a waiting result is
// stalled the input register holds, so at most two requests sit inside the block. The
// state update for a byte (marker match, length gather, byte countdown) is computed
// combinationally from the input register, which is what sets the one-byte-per-cycle
// rate. Write the payload length limit only while the block is idle.
module marker_length_deframer (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last,
   output logic [1:0]  rsp_status
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                advance;
   mld_pkg::result_type result;

   logic                rsp_valid_ff;
   logic [7:0]          rsp_payload_byte_ff;
   logic                rsp_last_ff;
   mld_pkg::status_type rsp_status_ff;

   // move a request forward when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_in_byte;
      end
   end

   mld_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .result      (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result.valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_byte_ff <= result.payload_byte;
         rsp_last_ff         <= result.last;
         rsp_status_ff       <= result.status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_byte = rsp_payload_byte_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

[src/mld_match.sv]
// mld_match: next marker match count for one stream byte
// depends on mld_pkg (marker table and length)
module mld_match (
   input  logic [3:0] progress,
   input  logic [7:0] data_byte,
   output logic [3:0] progress_next
);

   // advance on a match, otherwise restart; only the first marker byte can restart a match
   always_comb begin
      if ((progress < mld_pkg::MARKER_LEN_CODE) &&
          (data_byte == mld_pkg::marker_byte(progress))) begin
         progress_next = progress + 4'd1;
      end else if (data_byte == mld_pkg::MARKER_FIRST_BYTE) begin
         progress_next = 4'd1;
      end else begin
         progress_next = 4'd0;
      end
   end

endmodule

[src/mld_core.sv]
// mld_core: deframing state (phase, marker match, length gather, byte countdown) and result
// depends on mld_pkg and mld_match
module mld_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   output mld_pkg::result_type    result
);

   localparam int LEN_BITS = mld_pkg::LEN_BITS;

   mld_pkg::phase_type  phase_ff, phase_in;
   logic [3:0]          marker_progress_ff, marker_progress_in;
   logic [2:0]          header_byte_count_ff, header_byte_count_in;
   logic [LEN_BITS-1:0] length_accum_ff, length_accum_in;
   logic [31:0]         bytes_remaining_ff, bytes_remaining_in;
   logic [31:0]         max_payload_length_ff;

   logic [3:0]          progress_next;
   logic [LEN_BITS-1:0] len_full;
   logic [63:0]         len_wide;
   logic                len_negative;
   logic                len_too_long;
   logic [31:0]         remaining_dec;

   // limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_length_ff <= mld_pkg::MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_payload_length_ff <= csr_wr_data;
      end
   end

   mld_match u_match (
      .progress      (marker_progress_ff),
      .data_byte     (data_byte),
      .progress_next (progress_next)
   );

   // length with the current byte merged in
   assign len_full     = length_accum_ff |
                         (LEN_BITS'(data_byte) << {header_byte_count_ff, 3'b000});
   assign len_wide     = 64'(len_full);
   assign len_negative = len_full[LEN_BITS-1];
   assign len_too_long = (len_wide[63:32] != 32'd0) ||
                         (len_wide[31:0] > max_payload_length_ff);
   assign remaining_dec = bytes_remaining_ff - 32'd1;

   // next state and result
   always_comb begin
      phase_in             = phase_ff;
      marker_progress_in   = marker_progress_ff;
      header_byte_count_in = header_byte_count_ff;
      length_accum_in      = length_accum_ff;
      bytes_remaining_in   = bytes_remaining_ff;
      result.valid         = 1'b0;
      result.payload_byte  = 8'd0;
      result.last          = 1'b0;
      result.status        = mld_pkg::STATUS_PAYLOAD;

      unique case (phase_ff)
         mld_pkg::PHASE_LENGTH: begin
            if ((4'(header_byte_count_ff) + 4'd1) < 4'(mld_pkg::LENGTH_BYTES)) begin
               length_accum_in      = len_full;
               header_byte_count_in = header_byte_count_ff + 3'd1;
            end else if (len_negative || len_too_long) begin
               phase_in             = mld_pkg::PHASE_HUNT;
               marker_progress_in   = 4'd0;
               header_byte_count_in = 3'd0;
               length_accum_in      = '0;
               bytes_remaining_in   = 32'd0;
               result.valid         = 1'b1;
               result.last          = 1'b1;
               result.status        = mld_pkg::STATUS_REJECT;
            end else if (len_wide == 64'd0) begin
               phase_in             = mld_pkg::PHASE_HUNT;
               marker_progress_in   = 4'd0;
               header_byte_count_in = 3'd0;
               length_accum_in      = '0;
               bytes_remaining_in   = 32'd0;
               result.valid         = 1'b1;
               result.last          = 1'b1;
               result.status        = mld_pkg::STATUS_EMPTY;
            end else begin
               // accumulator is kept as is, cleared again when the next length starts
               length_accum_in      = len_full;
               phase_in             = mld_pkg::PHASE_PAYLOAD;
               marker_progress_in   = 4'd0;
               header_byte_count_in = 3'd0;
               bytes_remaining_in   = len_wide[31:0];
            end
         end

         mld_pkg::PHASE_PAYLOAD: begin
            result.valid = 1'b1;
            if (progress_next == mld_pkg::MARKER_LEN_CODE) begin
               // marker inside payload: abort and gather a new length
               phase_in             = mld_pkg::PHASE_LENGTH;
               marker_progress_in   = 4'd0;
               header_byte_count_in = 3'd0;
               length_accum_in      = '0;
               bytes_remaining_in   = 32'd0;
               result.last          = 1'b1;
               result.status        = mld_pkg::STATUS_ABORT;
            end else if (remaining_dec == 32'd0) begin
               phase_in             = mld_pkg::PHASE_HUNT;
               marker_progress_in   = 4'd0;
               header_byte_count_in = 3'd0;
               length_accum_in      = '0;
               bytes_remaining_in   = 32'd0;
               result.payload_byte  = data_byte;
               result.last          = 1'b1;
            end else begin
               marker_progress_in   = progress_next;
               bytes_remaining_in   = remaining_dec;
               result.payload_byte  = data_byte;
            end
         end

         default: begin
            // hunt, and the unused phase code
            if (progress_next == mld_pkg::MARKER_LEN_CODE) begin
               phase_in             = mld_pkg::PHASE_LENGTH;
               marker_progress_in   = 4'd0;
               header_byte_count_in = 3'd0;
               length_accum_in      = '0;
            end else begin
               phase_in             = mld_pkg::PHASE_HUNT;
               marker_progress_in   = progress_next;
            end
         end
      endcase
   end

   // state registers, updated once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff             <= mld_pkg::PHASE_HUNT;
         marker_progress_ff   <= 4'd0;
         header_byte_count_ff <= 3'd0;
         length_accum_ff      <= '0;
         bytes_remaining_ff   <= 32'd0;
      end else if (step) begin
         phase_ff             <= phase_in;
         marker_progress_ff   <= marker_progress_in;
         header_byte_count_ff <= header_byte_count_in;
         length_accum_ff      <= length_accum_in;
         bytes_remaining_ff   <= bytes_remaining_in;
      end
   end

   // a full marker never stays in the match count
   assert property (@(posedge clock) disable iff (reset)
      marker_progress_ff < mld_pkg::MARKER_LEN_CODE)
      else $error("marker match count reached marker length");

   // payload phase always has bytes left to pass on
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == mld_pkg::PHASE_PAYLOAD) |-> (bytes_remaining_ff != 32'd0))
      else $error("payload phase with no bytes remaining");

   // header byte count is only in use while gathering a length
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != mld_pkg::PHASE_LENGTH) |-> (header_byte_count_ff == 3'd0))
      else $error("stale header byte count outside length phase");

   // an abort always leads into a new length
   assert property (@(posedge clock) disable iff (reset)
      (step && result.valid && (result.status == mld_pkg::STATUS_ABORT))
      |=> (phase_ff == mld_pkg::PHASE_LENGTH))
      else $error("abort did not start a new length");

   // a frame end other than an abort returns to hunting
   assert property (@(posedge clock) disable iff (reset)
      (step && result.valid && result.last && (result.status != mld_pkg::STATUS_ABORT))
      |=> (phase_ff == mld_pkg::PHASE_HUNT))
      else $error("frame end did not resume hunting");

endmodule

[dv/tb.sv]
// tb: self-checking bench for marker_length_deframer, one byte request per handshake
// depends on mld_pkg (phase and status codes, widths, reset limit) and the deframer rtl
// a local deframing predictor feeds a queue of expected items checked on every response
module tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 300;
   localparam int SMALL_LEN    = 24;
   localparam int HOLD_LEN     = 40;

   // sync marker bytes in stream order
   localparam logic [7:0] MARKER_BYTES [mld_pkg::MARKER_LEN] = '{
      8'h44, 8'h41, 8'h54, 8'h41, 8'h5F, 8'h53, 8'h54, 8'h41, 8'h52, 8'h54
   };

   typedef struct packed {
      logic [7:0]          data;
      logic                last;
      mld_pkg::status_type status;
   } frame_item_type;

   // a request whose result is typed in by hand rather than predicted
   typedef struct packed {
      logic           fixed;
      frame_item_type item;
   } pinned_type;

   typedef enum logic [1:0] {
      ROW_BYTE   = 2'd0,
      ROW_MARKER = 2'd1,
      ROW_LENGTH = 2'd2
   } row_kind_type;

   typedef struct {
      row_kind_type   kind;
      logic [63:0]    value;
      logic           fixed;
      frame_item_type item;
   } stim_row_type;

   localparam frame_item_type ITEM_NONE   = '{8'h00, 1'b0, mld_pkg::STATUS_PAYLOAD};
   localparam frame_item_type ITEM_ABORT  = '{8'h00, 1'b1, mld_pkg::STATUS_ABORT};
   localparam frame_item_type ITEM_EMPTY  = '{8'h00, 1'b1, mld_pkg::STATUS_EMPTY};
   localparam frame_item_type ITEM_REJECT = '{8'h00, 1'b1, mld_pkg::STATUS_REJECT};

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = 32'd0;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_stall   = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last;
   logic [1:0]  rsp_status;

   // predictor state
   mld_pkg::phase_type pr_phase = mld_pkg::PHASE_HUNT;
   logic [3:0]  pr_match = '0;
   logic [2:0]  pr_hdr   = '0;
   logic [63:0] pr_len   = '0;
   logic [31:0] pr_left  = '0;
   logic [31:0] pr_max   = mld_pkg::MAX_LEN_RESET;

   frame_item_type expected_items[$];
   pinned_type     pinned_results[$];
   stim_row_type   stim_rows[$];

   int unsigned mismatches  = 0;
   int unsigned cycles      = 0;
   int unsigned items_sent  = 0;
   int unsigned hold_left   = 0;
   logic [31:0] limit_now   = mld_pkg::MAX_LEN_RESET;
   bit          quiet       = 1'b0;
   bit          hold_trigger = 1'b0;

   marker_length_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] marker_char(input int idx);
      return MARKER_BYTES[idx];
   endfunction

   // next marker match count; restarts at one on 'D' since it appears only once
   function automatic logic [3:0] marker_step(input logic [3:0] prog, input logic [7:0] b);
      if (prog < mld_pkg::MARKER_LEN_CODE && b == marker_char(int'(prog)))
         return prog + 4'd1;
      return (b == marker_char(0)) ? 4'd1 : 4'd0;
   endfunction

   function automatic void restart_hunt();
      pr_phase = mld_pkg::PHASE_HUNT;
      pr_match = '0;
      pr_hdr   = '0;
      pr_len   = '0;
      pr_left  = '0;
   endfunction

   function automatic void start_length();
      pr_phase = mld_pkg::PHASE_LENGTH;
      pr_match = '0;
      pr_hdr   = '0;
      pr_len   = '0;
   endfunction

   // deframe one byte, returns 1 when the byte produces a response item
   function automatic bit deframe_byte(input logic [7:0] b, output frame_item_type item);
      logic [3:0] nxt;
      item = ITEM_NONE;
      // length gather, little endian, no marker search here
      if (pr_phase == mld_pkg::PHASE_LENGTH) begin
         pr_len = pr_len | (64'(b) << (8 * pr_hdr));
         if (int'(pr_hdr) + 1 < mld_pkg::LENGTH_BYTES) begin
            pr_hdr = pr_hdr + 3'd1;
            return 1'b0;
         end
         if (pr_len[mld_pkg::LEN_BITS-1] || pr_len > {32'd0, pr_max}) begin
            restart_hunt();
            item = ITEM_REJECT;
            return 1'b1;
         end
         if (pr_len == 64'd0) begin
            restart_hunt();
            item = ITEM_EMPTY;
            return 1'b1;
         end
         pr_phase = mld_pkg::PHASE_PAYLOAD;
         pr_match = '0;
         pr_hdr   = '0;
         pr_left  = pr_len[31:0];
         return 1'b0;
      end
      nxt = marker_step(pr_match, b);
      // payload: a completed marker wins over the last byte
      if (pr_phase == mld_pkg::PHASE_PAYLOAD) begin
         if (nxt == mld_pkg::MARKER_LEN_CODE) begin
            pr_left = '0;
            start_length();
            item = ITEM_ABORT;
            return 1'b1;
         end
         pr_match    = nxt;
         pr_left     = pr_left - 32'd1;
         item.data   = b;
         item.status = mld_pkg::STATUS_PAYLOAD;
         if (pr_left == 32'd0) begin
            restart_hunt();
            item.last = 1'b1;
         end
         return 1'b1;
      end
      // hunt
      if (nxt == mld_pkg::MARKER_LEN_CODE)
         start_length();
      else
         pr_match = nxt;
      return 1'b0;
   endfunction

   function automatic logic [7:0] payload_pick();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0)
         return marker_char(0);
      if (pick == 1)
         return marker_char($urandom_range(mld_pkg::MARKER_LEN - 1));
      return 8'($urandom());
   endfunction

   function automatic void add_row(input row_kind_type kind, input logic [63:0] value,
                                   input logic fixed, input frame_item_type item);
      stim_row_type row;
      row = '{kind, value, fixed, item};
      stim_rows.insert(stim_rows.size(), row);
   endfunction

   task automatic flag_mismatch(input string what, input frame_item_type want,
                                input frame_item_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch (%0s) at cycle %0d: expected byte %02h last %0b status %0d,",
                  what, cycles, want.data, want.last, want.status,
                  " got byte %02h last %0b status %0d", got.data, got.last, got.status);
   endtask

   // present one request and hold it until accepted
   task automatic send_byte(input logic [7:0] b, input logic fixed, input frame_item_type item);
      pinned_type pin;
      if (!quiet && $urandom_range(99) < 14) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      pin = '{fixed, item};
      pinned_results.insert(pinned_results.size(), pin);
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_marker(input logic fixed, input frame_item_type item);
      for (int i = 0; i < mld_pkg::MARKER_LEN; i++)
         send_byte(marker_char(i), fixed && i == mld_pkg::MARKER_LEN - 1, item);
   endtask

   task automatic send_length(input logic [63:0] len, input logic fixed,
                              input frame_item_type item);
      for (int i = 0; i < mld_pkg::LENGTH_BYTES; i++)
         send_byte(len[8*i +: 8], fixed && i == mld_pkg::LENGTH_BYTES - 1, item);
   endtask

   // stop sending and wait until every expected item has come out
   task automatic settle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (expected_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      limit_now    = value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // length plus payload after a marker; a cut frame carries a marker and a new length
   task automatic random_frame_body();
      bit          again     = 1'b1;
      bit          may_abort = 1'b1;
      bit          cut;
      int unsigned pick;
      int unsigned n;
      logic [63:0] len;
      while (again) begin
         again = 1'b0;
         pick  = may_abort ? $urandom_range(99) : 0;
         if (pick < 55)
            len = 64'($urandom_range(SMALL_LEN));
         else if (pick < 65)
            len = 64'(limit_now) + 64'($urandom_range(1));
         else if (pick < 75)
            len = {1'b1, 31'($urandom()), 32'($urandom())};
         else if (pick < 85)
            len = {1'b0, 31'($urandom_range(1, 32'h7FFF_FFFF)), 32'($urandom())};
         else
            len = 64'($urandom());
         send_length(len, 1'b0, ITEM_NONE);
         cut = (len > SMALL_LEN) || (len != 0 && may_abort && $urandom_range(99) < 12);
         if (!cut)
            n = int'(len);
         else if (len > SMALL_LEN)
            n = $urandom_range(8);
         else
            n = $urandom_range(int'(len) - 1);
         repeat (n) send_byte(payload_pick(), 1'b0, ITEM_NONE);
         if (cut) begin
            send_marker(1'b0, ITEM_NONE);
            again     = 1'b1;
            may_abort = 1'b0;
         end
      end
   endtask

   task automatic random_traffic(input int unsigned n_items);
      int unsigned start;
      int unsigned pick;
      int unsigned span;
      start = items_sent;
      while (items_sent - start < n_items) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_marker(1'b0, ITEM_NONE);
            random_frame_body();
         end else if (pick < 85) begin
            // hunt noise
            repeat ($urandom_range(1, 6)) send_byte(payload_pick(), 1'b0, ITEM_NONE);
         end else begin
            // broken marker
            span = $urandom_range(1, mld_pkg::MARKER_LEN - 1);
            for (int i = 0; i < int'(span); i++)
               send_byte(marker_char(i), 1'b0, ITEM_NONE);
            send_byte(8'($urandom()), 1'b0, ITEM_NONE);
         end
      end
   endtask

   // receiver stall, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_trigger) begin
         rsp_stall <= 1'b1;
         hold_left  = HOLD_CYCLES;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 17);
      end
   end

   // response check, then prediction for the request taken at this edge
   always @(posedge clock) begin
      frame_item_type got;
      frame_item_type want;
      frame_item_type pred;
      pinned_type     pin;
      bit             has_pred;
      if (!reset) begin
         if (csr_wr_en)
            pr_max = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_payload_byte, rsp_last, mld_pkg::status_type'(rsp_status)};
            if (expected_items.size() == 0) begin
               flag_mismatch("no item expected", ITEM_NONE, got);
            end else begin
               want = expected_items.pop_front();
               if (got.data !== want.data || got.last !== want.last ||
                   got.status !== want.status)
                  flag_mismatch("field", want, got);
            end
         end
         if (req_valid && !req_stall) begin
            pin      = (pinned_results.size() != 0) ? pinned_results.pop_front() : '0;
            has_pred = deframe_byte(req_in_byte, pred);
            if (pin.fixed)
               expected_items.insert(expected_items.size(), pin.item);
            else if (has_pred)
               expected_items.insert(expected_items.size(), pred);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, limit at its reset value
      add_row(ROW_BYTE,   64'hFF, 1'b0, ITEM_NONE);
      add_row(ROW_BYTE,   64'h00, 1'b0, ITEM_NONE);
      // stray 'D' ahead of the marker restarts the match
      add_row(ROW_BYTE,   64'h44, 1'b0, ITEM_NONE);
      add_row(ROW_MARKER, 64'd0,  1'b0, ITEM_NONE);
      add_row(ROW_LENGTH, 64'd0,  1'b1, ITEM_EMPTY);
      add_row(ROW_MARKER, 64'd0,  1'b0, ITEM_NONE);
      add_row(ROW_LENGTH, 64'h8000_0000_0000_0000, 1'b1, ITEM_REJECT);
      add_row(ROW_MARKER, 64'd0,  1'b0, ITEM_NONE);
      add_row(ROW_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ITEM_REJECT);
      add_row(ROW_MARKER, 64'd0,  1'b0, ITEM_NONE);
      add_row(ROW_LENGTH, 64'd65537, 1'b1, ITEM_REJECT);
      add_row(ROW_MARKER, 64'd0,  1'b0, ITEM_NONE);
      add_row(ROW_LENGTH, 64'd1,  1'b0, ITEM_NONE);
      add_row(ROW_BYTE,   64'hFF, 1'b1, '{8'hFF, 1'b1, mld_pkg::STATUS_PAYLOAD});
      add_row(ROW_MARKER, 64'd0,  1'b0, ITEM_NONE);
      add_row(ROW_LENGTH, 64'd2,  1'b0, ITEM_NONE);
      add_row(ROW_BYTE,   64'h00, 1'b1, '{8'h00, 1'b0, mld_pkg::STATUS_PAYLOAD});
      add_row(ROW_BYTE,   64'h80, 1'b1, '{8'h80, 1'b1, mld_pkg::STATUS_PAYLOAD});
      // marker inside a longer payload, then a new length right away
      add_row(ROW_MARKER, 64'd0,  1'b0, ITEM_NONE);
      add_row(ROW_LENGTH, 64'd12, 1'b0, ITEM_NONE);
      add_row(ROW_MARKER, 64'd0,  1'b1, ITEM_ABORT);
      add_row(ROW_LENGTH, 64'd1,  1'b0, ITEM_NONE);
      add_row(ROW_BYTE,   64'h5A, 1'b0, ITEM_NONE);
      // marker ending exactly on what would be the last payload byte
      add_row(ROW_MARKER, 64'd0,  1'b0, ITEM_NONE);
      add_row(ROW_LENGTH, 64'd10, 1'b0, ITEM_NONE);
      add_row(ROW_MARKER, 64'd0,  1'b1, ITEM_ABORT);
      add_row(ROW_LENGTH, 64'd0,  1'b1, ITEM_EMPTY);
      // length equal to the limit, cut short, then one above 32 bits
      add_row(ROW_MARKER, 64'd0,  1'b0, ITEM_NONE);
      add_row(ROW_LENGTH, 64'd65536, 1'b0, ITEM_NONE);
      add_row(ROW_BYTE,   64'h01, 1'b0, ITEM_NONE);
      add_row(ROW_MARKER, 64'd0,  1'b1, ITEM_ABORT);
      add_row(ROW_LENGTH, 64'h0000_0001_0000_0000, 1'b1, ITEM_REJECT);

      foreach (stim_rows[r]) begin
         case (stim_rows[r].kind)
            ROW_MARKER: send_marker(stim_rows[r].fixed, stim_rows[r].item);
            ROW_LENGTH: send_length(stim_rows[r].value, stim_rows[r].fixed, stim_rows[r].item);
            default:    send_byte(stim_rows[r].value[7:0], stim_rows[r].fixed, stim_rows[r].item);
         endcase
      end

      // zero limit: every nonzero length is rejected
      write_limit(32'd0);
      random_traffic(80);

      // full limit, no idling on either side
      write_limit(32'hFFFF_FFFF);
      quiet = 1'b1;
      random_traffic(90);
      quiet = 1'b0;

      // small limit so accepted and rejected lengths mix
      write_limit(32'd12);
      random_traffic(90);

      // long receiver hold-off while a frame keeps coming
      write_limit($urandom_range(300, 70000));
      hold_trigger = 1'b1;
      send_marker(1'b0, ITEM_NONE);
      hold_trigger = 1'b0;
      send_length(64'(HOLD_LEN), 1'b0, ITEM_NONE);
      repeat (HOLD_LEN) send_byte(8'($urandom()), 1'b0, ITEM_NONE);
      random_traffic(70);

      // sender pause until the pipe is empty, limit unchanged
      settle();
      random_traffic(70);

      settle();
      if (mismatches == 0 && expected_items.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
src/mld_pkg.sv
src/mld_match.sv
src/mld_core.sv
src/marker_length_deframer.sv
dv/tb.sv
